[sv/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// tgr_pkg
// shared types and constants for the text glyph renderer
// ----------------------------------------------------------------------------
package tgr_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int CODE_W   = 8;
  localparam int STORE_AW = 12;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 48;
  localparam int COLOR_W  = 32;
  localparam int COORD_W  = 16;
  localparam int GB_W     = 5;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 48;

  // pixel offset: (y + rows) * pitch + x stays below 2^34
  localparam int PIX_W    = 34;

  // cursor steps
  localparam logic [COORD_W-1:0] CHAR_STEP = 16'd8;
  localparam logic [COORD_W-1:0] LINE_STEP = 16'd16;

  localparam logic [GB_W-1:0] GB_RESET = 5'd16;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_HOME = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_COLOUR       = 3'd0,
    REG_FRAME_BASE   = 3'd1,
    REG_SCAN_PITCH   = 3'd2,
    REG_SCREEN_WIDTH = 3'd3,
    REG_GLYPH_BYTES  = 3'd4
  } reg_idx_t;

  // draw sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROWS
  } state_t;

endpackage

[sv/text_glyph_renderer_unit.sv]
// ----------------------------------------------------------------------------
// text_glyph_renderer_unit
// renders 8-pixel-wide glyphs from an internal font store into row writes
// for a 32-bit-per-pixel framebuffer
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  command, char_code, font_index, font_byte
//  out      out_valid/out_stall  row_address, pixel_mask, pixel_colour, last_row
//  cfg      cfg_we               cfg_index, cfg_data (write only)
//
//  load and home requests complete when they are taken. a draw request runs
//  the sequencer through the cursor_y * scan_pitch product, then the addition
//  of cursor_x, then one glyph row per cycle while out_stall allows, through
//  the single read port of the font store. each row passes from the read stage
//  to the output register. rst clears the cursor, the registers and the
//  pipeline valids; the font store is not cleared. out_stall holds the output
//  register and the read stage, and the sequencer waits for them; in_stall is high while drawing.
//
module text_glyph_renderer_unit #(
  parameter int GLYPH_ROWS      = 9,
  parameter int MAX_GLYPH_BYTES = 16
) (
  input  logic                              clk,
  input  logic                              rst,

  // configuration writes
  input  logic                              cfg_we,
  input  logic [tgr_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [tgr_pkg::CFG_DW-1:0]        cfg_data,

  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tgr_pkg::CMD_W-1:0]         command,
  input  logic [tgr_pkg::CODE_W-1:0]        char_code,
  input  logic [tgr_pkg::STORE_AW-1:0]      font_index,
  input  logic [tgr_pkg::BYTE_W-1:0]        font_byte,

  // row channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tgr_pkg::ADDR_W-1:0]        row_address,
  output logic [tgr_pkg::BYTE_W-1:0]        pixel_mask,
  output logic [tgr_pkg::COLOR_W-1:0]       pixel_colour,
  output logic                              last_row
);

  localparam int ROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int SAT_W  = $clog2(MAX_GLYPH_BYTES + 1);
  localparam int GBC_W  = (SAT_W > tgr_pkg::GB_W) ? SAT_W : tgr_pkg::GB_W;
  localparam int STORE_DEPTH = 1 << tgr_pkg::STORE_AW;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);
  localparam logic [GBC_W-1:0] GB_MAX   = GBC_W'(MAX_GLYPH_BYTES);

  // configuration registers
  logic [tgr_pkg::COLOR_W-1:0] colour;
  logic [tgr_pkg::ADDR_W-1:0]  frame_base;
  logic [tgr_pkg::COORD_W-1:0] scan_pitch;
  logic [tgr_pkg::COORD_W-1:0] screen_width;
  logic [tgr_pkg::GB_W-1:0]    glyph_bytes;

  // cursor
  logic [tgr_pkg::COORD_W-1:0] cursor_x;
  logic [tgr_pkg::COORD_W-1:0] cursor_y;

  // sequencer
  tgr_pkg::state_t state, state_next;
  logic [2*tgr_pkg::COORD_W-1:0] row_prod;   // cursor_y * scan_pitch
  logic [tgr_pkg::COORD_W-1:0]   draw_x;
  logic [tgr_pkg::PIX_W-1:0]     pix;        // pixel offset of current row
  logic [tgr_pkg::STORE_AW-1:0]  glyph_idx;  // store address of current row
  logic [ROW_W-1:0]              row;

  // read stage
  logic                          rd_valid;
  logic [tgr_pkg::ADDR_W-1:0]    rd_addr;
  logic                          rd_last;
  logic [tgr_pkg::BYTE_W-1:0]    rd_data;

  // font store
  logic [tgr_pkg::BYTE_W-1:0] glyph_store [STORE_DEPTH];

  logic in_accept;
  logic out_free;
  logic issue;
  logic is_load, is_draw, is_home;
  logic [GBC_W-1:0] gb_ext;
  logic [GBC_W-1:0] gb_sat;
  logic [tgr_pkg::CODE_W+GBC_W-1:0] code_prod;
  logic [tgr_pkg::COORD_W-1:0] x_step;
  logic line_wrap;

  assign in_stall  = (state != tgr_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_load   = in_accept && (command == tgr_pkg::CMD_LOAD);
  assign is_draw   = in_accept && (command == tgr_pkg::CMD_DRAW);
  assign is_home   = in_accept && (command == tgr_pkg::CMD_HOME);

  // output register is free when empty or being taken
  assign out_free = !out_valid || !out_stall;
  // a new store read may start when the read stage is empty or moves on
  assign issue    = (state == tgr_pkg::ST_ROWS) && (!rd_valid || out_free);

  // glyph size saturates at MAX_GLYPH_BYTES; zero is used as it is
  assign gb_ext    = GBC_W'(glyph_bytes);
  assign gb_sat    = (gb_ext > GB_MAX) ? GB_MAX : gb_ext;
  assign code_prod = (tgr_pkg::CODE_W+GBC_W)'(char_code) *
                     (tgr_pkg::CODE_W+GBC_W)'(gb_sat);

  // cursor advance with line wrap; the wrap test adds the second step in 17 bits
  assign x_step    = cursor_x + tgr_pkg::CHAR_STEP;
  assign line_wrap = ({1'b0, x_step} + {1'b0, tgr_pkg::CHAR_STEP}) >
                     {1'b0, screen_width};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      colour       <= '0;
      frame_base   <= '0;
      scan_pitch   <= '0;
      screen_width <= '0;
      glyph_bytes  <= tgr_pkg::GB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgr_pkg::REG_COLOUR:       colour       <= cfg_data[tgr_pkg::COLOR_W-1:0];
        tgr_pkg::REG_FRAME_BASE:   frame_base   <= cfg_data[tgr_pkg::ADDR_W-1:0];
        tgr_pkg::REG_SCAN_PITCH:   scan_pitch   <= cfg_data[tgr_pkg::COORD_W-1:0];
        tgr_pkg::REG_SCREEN_WIDTH: screen_width <= cfg_data[tgr_pkg::COORD_W-1:0];
        tgr_pkg::REG_GLYPH_BYTES:  glyph_bytes  <= cfg_data[tgr_pkg::GB_W-1:0];
        default: ;
      endcase
    end
  end

  // cursor moves when a draw is taken and clears on home; its old value is captured for the rows
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (is_home) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (is_draw) begin
      if (line_wrap) begin
        cursor_x <= '0;
        cursor_y <= cursor_y + tgr_pkg::LINE_STEP;
      end else begin
        cursor_x <= x_step;
      end
    end
  end

  // font store write port
  always_ff @(posedge clk) begin
    if (is_load) begin
      glyph_store[font_index] <= font_byte;
    end
  end

  // font store read port, data held while the read stage is stalled
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= glyph_store[glyph_idx];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tgr_pkg::ST_IDLE: begin
        if (is_draw) state_next = tgr_pkg::ST_SETUP;
      end
      tgr_pkg::ST_SETUP: begin
        state_next = tgr_pkg::ST_ROWS;
      end
      tgr_pkg::ST_ROWS: begin
        if (issue && row == LAST_ROW) state_next = tgr_pkg::ST_IDLE;
      end
      default: state_next = tgr_pkg::ST_IDLE;
    endcase
  end

  // per-draw datapath: product, then start offset, then one row per issue
  always_ff @(posedge clk) begin
    if (is_draw) begin
      row_prod  <= (2*tgr_pkg::COORD_W)'(cursor_y) * (2*tgr_pkg::COORD_W)'(scan_pitch);
      draw_x    <= cursor_x;
      glyph_idx <= code_prod[tgr_pkg::STORE_AW-1:0];
      row       <= '0;
    end
    if (state == tgr_pkg::ST_SETUP) begin
      pix <= tgr_pkg::PIX_W'(row_prod) + tgr_pkg::PIX_W'(draw_x);
    end
    if (issue) begin
      pix       <= pix + tgr_pkg::PIX_W'(scan_pitch);
      glyph_idx <= glyph_idx + 1'b1;
      row       <= row + 1'b1;
    end
  end

  // read stage metadata, lined up with rd_data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (out_free) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr <= frame_base + tgr_pkg::ADDR_W'({pix, 2'b00});
      rd_last <= (row == LAST_ROW);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && rd_valid) begin
      row_address  <= rd_addr;
      pixel_mask   <= rd_data;
      pixel_colour <= colour;
      last_row     <= rd_last;
    end
  end

endmodule

[dv/text_glyph_renderer_checker.sv]
// ----------------------------------------------------------------------------
// text_glyph_renderer_checker
// watches the register port and both channels of the glyph renderer, keeps
// its own font store, registers and text cursor, works out the GLYPH_ROWS row
// writes of every accepted draw and compares them with the rows that leave
// ----------------------------------------------------------------------------
module text_glyph_renderer_checker
  import tgr_pkg::*;
#(
  parameter int GLYPH_ROWS      = 9,
  parameter int MAX_GLYPH_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [CODE_W-1:0]     char_code,
  input  logic [STORE_AW-1:0]   font_index,
  input  logic [BYTE_W-1:0]     font_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [ADDR_W-1:0]     row_address,
  input  logic [BYTE_W-1:0]     pixel_mask,
  input  logic [COLOR_W-1:0]    pixel_colour,
  input  logic                  last_row,
  output int                    error_count,
  output int                    rows_pending,
  output int                    rows_checked
);

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  mask;
    logic [COLOR_W-1:0] colour;
    logic               last;
  } glyph_row_t;

  glyph_row_t         rows_due [$];
  glyph_row_t         want;
  logic [BYTE_W-1:0]  font_copy [1 << STORE_AW];

  logic [COLOR_W-1:0] colour_reg;
  logic [ADDR_W-1:0]  base_reg;
  logic [COORD_W-1:0] pitch_reg;
  logic [COORD_W-1:0] width_reg;
  logic [GB_W-1:0]    glyph_size;
  logic [COORD_W-1:0] pen_x;
  logic [COORD_W-1:0] pen_y;

  int fails   = 0;
  int checked = 0;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] wanted);
    if (fails < 64)
      $display("row %0d: %s is 0x%0h, expected 0x%0h", checked, what, got, wanted);
    fails++;
  endtask

  // GLYPH_ROWS row writes for one character, then the cursor step
  task automatic render_char(input logic [CODE_W-1:0] code);
    int unsigned        step;
    logic [63:0]        pix;
    logic [STORE_AW-1:0] at;
    glyph_row_t         row;
    step = (glyph_size > MAX_GLYPH_BYTES) ? MAX_GLYPH_BYTES : glyph_size;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      at         = STORE_AW'(code * step + r);
      pix        = 64'(pen_x) + (64'(pen_y) + 64'(r)) * 64'(pitch_reg);
      row.addr   = ADDR_W'(64'(base_reg) + (pix << 2));
      row.mask   = font_copy[at];
      row.colour = colour_reg;
      row.last   = (r == GLYPH_ROWS - 1);
      rows_due.push_back(row);
    end
    pen_x = pen_x + CHAR_STEP;
    if ({1'b0, pen_x} + {1'b0, CHAR_STEP} > {1'b0, width_reg}) begin
      pen_x = '0;
      pen_y = pen_y + LINE_STEP;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      colour_reg = '0;
      base_reg   = '0;
      pitch_reg  = '0;
      width_reg  = '0;
      glyph_size = GB_RESET;
      pen_x      = '0;
      pen_y      = '0;
      rows_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLOUR:       colour_reg = cfg_data[COLOR_W-1:0];
          REG_FRAME_BASE:   base_reg   = cfg_data[ADDR_W-1:0];
          REG_SCAN_PITCH:   pitch_reg  = cfg_data[COORD_W-1:0];
          REG_SCREEN_WIDTH: width_reg  = cfg_data[COORD_W-1:0];
          REG_GLYPH_BYTES:  glyph_size = cfg_data[GB_W-1:0];
          default: ;
        endcase
      end

      // requests first, so a row leaving in the same cycle still finds its entry
      if (in_valid && !in_stall) begin
        case (command)
          CMD_LOAD: font_copy[font_index] = font_byte;
          CMD_DRAW: render_char(char_code);
          CMD_HOME: begin
            pen_x = '0;
            pen_y = '0;
          end
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          flag_mismatch("unexpected row, address", 64'(row_address), 64'd0);
        end else begin
          want = rows_due.pop_front();
          if (row_address !== want.addr)
            flag_mismatch("row_address", 64'(row_address), 64'(want.addr));
          if (pixel_mask !== want.mask)
            flag_mismatch("pixel_mask", 64'(pixel_mask), 64'(want.mask));
          if (pixel_colour !== want.colour)
            flag_mismatch("pixel_colour", 64'(pixel_colour), 64'(want.colour));
          if (last_row !== want.last)
            flag_mismatch("last_row", 64'(last_row), 64'(want.last));
          checked++;
        end
      end
    end
    error_count  <= fails;
    rows_checked <= checked;
    rows_pending <= rows_due.size();
  end

endmodule

[dv/text_glyph_renderer_unit_tb.sv]
// ----------------------------------------------------------------------------
// text_glyph_renderer_unit_tb
// drives font loads, character draws and cursor homes into the renderer
// under a series of register settings, with random gaps on the request side
// and random stalls on the row side; a separate checker predicts every row
// write and this top turns its error count into the verdict
// ----------------------------------------------------------------------------
module text_glyph_renderer_unit_tb;
  import tgr_pkg::*;

  localparam int GLYPH_ROWS      = 9;
  localparam int MAX_GLYPH_BYTES = 16;

  // a draw passes the sequencer and then two output stages, the read stage and the output register
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 48;
  // at zero screen width every draw steps down a line
  localparam int WRAP_DRAWS   = 4;
  localparam int CYCLE_LIMIT  = 100_000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_we       = 1'b0;
  logic [CFG_IW-1:0]   cfg_index    = '0;
  logic [CFG_DW-1:0]   cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command      = CMD_HOME;
  logic [CODE_W-1:0]   char_code    = '0;
  logic [STORE_AW-1:0] font_index   = '0;
  logic [BYTE_W-1:0]   font_byte    = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [ADDR_W-1:0]   row_address;
  logic [BYTE_W-1:0]   pixel_mask;
  logic [COLOR_W-1:0]  pixel_colour;
  logic                last_row;

  int error_count;
  int rows_pending;
  int rows_checked;

  // stimulus bookkeeping
  bit              font_loaded [1 << STORE_AW];
  logic [GB_W-1:0] glyph_size     = GB_RESET;
  logic            sender_idles   = 1'b1;
  logic            receiver_idles = 1'b1;
  int              hold_asks      = 0;
  int              holds_done     = 0;
  int              items_sent     = 0;
  int              draws_sent     = 0;
  int              loads_sent     = 0;
  int              homes_sent     = 0;
  int              cycles         = 0;

  text_glyph_renderer_unit #(
    .GLYPH_ROWS      (GLYPH_ROWS),
    .MAX_GLYPH_BYTES (MAX_GLYPH_BYTES)
  ) DUT (.*);

  text_glyph_renderer_checker #(
    .GLYPH_ROWS      (GLYPH_ROWS),
    .MAX_GLYPH_BYTES (MAX_GLYPH_BYTES)
  ) row_checker (.*);

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("text_glyph_renderer_unit regression: fail");
      $finish;
    end
  end

  // row side: random stalls, plus a long hold-off whenever the stimulus asks
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= receiver_idles && ($urandom_range(99) < 31);
    end
  end

  // store entry that row r of a character reads under the current glyph size
  function automatic logic [STORE_AW-1:0] font_row_index(input logic [CODE_W-1:0] code,
                                                         input int r);
    int unsigned step;
    step = (glyph_size > MAX_GLYPH_BYTES) ? MAX_GLYPH_BYTES : glyph_size;
    return STORE_AW'(code * step + r);
  endfunction

  // a draw is only sent once every row it reads has been loaded
  function automatic bit glyph_ready(input logic [CODE_W-1:0] code);
    for (int r = 0; r < GLYPH_ROWS; r++)
      if (!font_loaded[font_row_index(code, r)]) return 1'b0;
    return 1'b1;
  endfunction

  // extremes show up often, the rest comes from 8..160 or the whole range
  function automatic logic [COORD_W-1:0] pick_span();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return COORD_W'($urandom_range(8, 160));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  // register write; cfg_we is low again before the task returns, so it never toggles in a step
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GLYPH_BYTES) glyph_size = value[GB_W-1:0];
    @(posedge clk);
  endtask

  // one request through the valid/stall handshake, with random gaps ahead of it
  task automatic send_request(input cmd_t cmd, input logic [CODE_W-1:0] code,
                              input logic [STORE_AW-1:0] at,
                              input logic [BYTE_W-1:0] data);
    while (sender_idles && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    char_code  <= code;
    font_index <= at;
    font_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (cmd)
      CMD_LOAD: begin
        font_loaded[at] = 1'b1;
        loads_sent++;
      end
      CMD_DRAW: draws_sent++;
      CMD_HOME: homes_sent++;
      default: ;
    endcase
    // the unused command is ignored by the block and does not count
    if (cmd != CMD_NONE) items_sent++;
  endtask

  task automatic send_load(input logic [STORE_AW-1:0] at, input logic [BYTE_W-1:0] data);
    send_request(CMD_LOAD, CODE_W'($urandom), at, data);
  endtask

  task automatic send_draw(input logic [CODE_W-1:0] code);
    send_request(CMD_DRAW, code, STORE_AW'($urandom), BYTE_W'($urandom));
  endtask

  // pick a character and load its rows: missing ones always, others now and then
  task automatic load_glyph(output logic [CODE_W-1:0] code);
    logic [STORE_AW-1:0] at;
    code = pick_code();
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      at = font_row_index(code, r);
      if (!font_loaded[at] || $urandom_range(1) == 1) send_load(at, BYTE_W'($urandom));
    end
  endtask

  // stop offering, wait for every row to leave, then let the block settle
  task automatic drain_rows();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic pick_settings();
    int pick;
    pick = $urandom_range(9);
    write_reg(REG_COLOUR, CFG_DW'($urandom));
    write_reg(REG_FRAME_BASE, {16'($urandom), 32'($urandom)});
    write_reg(REG_SCAN_PITCH, CFG_DW'(pick_span()));
    write_reg(REG_SCREEN_WIDTH, CFG_DW'(pick_span()));
    // mostly in-range glyph sizes, sometimes zero or above the store limit
    if (pick == 0)
      write_reg(REG_GLYPH_BYTES, '0);
    else if (pick == 1)
      write_reg(REG_GLYPH_BYTES, CFG_DW'($urandom_range(MAX_GLYPH_BYTES + 1, 31)));
    else
      write_reg(REG_GLYPH_BYTES, CFG_DW'($urandom_range(1, MAX_GLYPH_BYTES)));
  endtask

  initial begin
    logic [BYTE_W-1:0] first_glyph [GLYPH_ROWS];
    logic [CODE_W-1:0] code;
    int                phase;
    int                target;

    first_glyph = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h3C};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: narrow screen so the third draw moves the cursor to the next line
    write_reg(REG_COLOUR, 48'hFFFF_FFFF);
    write_reg(REG_FRAME_BASE, 48'h1000);
    write_reg(REG_SCAN_PITCH, 48'd640);
    write_reg(REG_SCREEN_WIDTH, 48'd24);
    write_reg(REG_GLYPH_BYTES, 48'd16);
    // character 0 reads entries 0..8 under every glyph size, so load them first
    for (int r = 0; r < GLYPH_ROWS; r++) send_load(STORE_AW'(r), first_glyph[r]);
    send_load('1, '1);
    repeat (3) send_draw('0);
    send_request(CMD_NONE, '1, '1, '1);
    send_request(CMD_HOME, '0, '0, '0);
    send_draw('0);
    drain_rows();

    // zero glyph size: every character reads entries 0..8; address wraps past 2^48
    write_reg(REG_GLYPH_BYTES, '0);
    write_reg(REG_FRAME_BASE, 48'hFFFF_FFFF_FFFC);
    write_reg(REG_SCAN_PITCH, 48'hFFFF);
    write_reg(REG_SCREEN_WIDTH, '0);
    write_reg(REG_COLOUR, '0);
    send_draw('1);
    send_draw(8'h80);
    drain_rows();

    // glyph sizes above the store limit saturate
    write_reg(REG_GLYPH_BYTES, 48'd31);
    send_draw('0);
    drain_rows();
    write_reg(REG_GLYPH_BYTES, CFG_DW'(MAX_GLYPH_BYTES + 1));
    send_draw('0);
    drain_rows();

    // ---- random: four settings, mostly load-then-draw sequences
    for (phase = 0; phase < 4; phase++) begin
      pick_settings();
      // last phase runs with no gaps and no stalls at all
      sender_idles   <= (phase != 3);
      receiver_idles <= (phase != 3);
      if (phase == 1) begin
        // long row hold-off while draws keep coming, so the block backs up
        load_glyph(code);
        hold_asks <= hold_asks + 1;
        repeat (4) send_draw(code);
      end
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        case ($urandom_range(9))
          0: send_load(STORE_AW'($urandom), BYTE_W'($urandom));
          1: send_request(CMD_HOME, CODE_W'($urandom), STORE_AW'($urandom),
                          BYTE_W'($urandom));
          2: send_request(CMD_NONE, CODE_W'($urandom), STORE_AW'($urandom),
                          BYTE_W'($urandom));
          3: begin
            // broken sequence: a few rows of a glyph and no draw
            code = pick_code();
            repeat ($urandom_range(1, 4))
              send_load(font_row_index(code, $urandom_range(GLYPH_ROWS - 1)),
                        BYTE_W'($urandom));
          end
          4: begin
            code = CODE_W'($urandom);
            send_draw(glyph_ready(code) ? code : '0);
          end
          default: begin
            load_glyph(code);
            repeat ($urandom_range(1, 3)) send_draw(code);
          end
        endcase
      end
      drain_rows();
    end

    // ---- zero screen width: every draw steps a line
    write_reg(REG_SCREEN_WIDTH, '0);
    write_reg(REG_SCAN_PITCH, 48'hFFFF);
    write_reg(REG_FRAME_BASE, {16'($urandom), 32'($urandom)});
    write_reg(REG_COLOUR, CFG_DW'($urandom));
    send_request(CMD_HOME, '0, '0, '0);
    load_glyph(code);
    repeat (WRAP_DRAWS) send_draw(code);
    drain_rows();

    $display("covered %0d draws, %0d font loads, %0d cursor homes; %0d rows checked",
             draws_sent, loads_sent, homes_sent, rows_checked);
    $display("glyph sizes zero, in range and saturated; line wrap and address wrap");
    if (error_count == 0 && rows_pending == 0)
      $display("text_glyph_renderer_unit regression: pass");
    else
      $display("text_glyph_renderer_unit regression: fail");
    $finish;
  end

endmodule

[text_glyph_renderer_unit.f]
sv/tgr_pkg.sv
sv/text_glyph_renderer_unit.sv
dv/text_glyph_renderer_checker.sv
dv/text_glyph_renderer_unit_tb.sv
